@@ rtl/bsr_pkg.sv @@
`timescale 1ns / 1ps
package bsr_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);

  typedef enum logic [2:0] {
    MODE_POINT  = 3'd0,
    MODE_RECT   = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_TRI    = 3'd3,
    MODE_CIRCLE = 3'd4,
    MODE_CLEAR  = 3'd5,
    MODE_READ   = 3'd6,
    MODE_NOP    = 3'd7
  } mode_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [7:0] start_row;
    logic signed [7:0] start_col;
    logic signed [7:0] end_row;
    logic signed [7:0] end_col;
    logic [7:0]        size_h;
    logic [7:0]        size_w;
  } cmd_t;

  typedef struct packed {
    logic [63:0] row_bits;
    logic        was_read;
  } res_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_SQ,
    DP_ROOT,
    DP_RD,
    DP_WR
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic root_done;
    logic is_circle;
  } dp_stat_t;

  // Columns lo..hi, clipped to 0..nc-1; zero when nothing is left.
  function automatic logic [63:0] span_mask(logic signed [9:0] lo,
                                            logic signed [9:0] hi,
                                            logic [6:0] nc);
    logic signed [10:0] lo_c;
    logic signed [10:0] hi_c;
    logic signed [10:0] top;
    logic [63:0]        m;
    lo_c = {lo[9], lo};
    hi_c = {hi[9], hi};
    top  = $signed({4'b0, nc}) - 11'sd1;
    if (lo_c < 0) lo_c = 11'sd0;
    if (hi_c > top) hi_c = top;
    if (hi_c < lo_c) begin
      m = '0;
    end else begin
      m = ({64{1'b1}} << lo_c[5:0]) & ({64{1'b1}} >> (6'd63 - hi_c[5:0]));
    end
    return m;
  endfunction

endpackage

@@ rtl/bitmap_shape_rasterizer.sv @@
`timescale 1ns / 1ps
// One-bit-per-pixel canvas (64 x 64) with shape drawing commands.
// Command channel: raise start with cmd valid; the command is taken at a
// clock edge where start is high and busy is low. busy stays high until
// the result has gone out. Each command gives one result on result,
// marked by done for exactly one cycle; the receiver cannot stall it.
// Config: cfg_we writes cfg_data into rows_in_use (index 0) or
// cols_in_use (index 1) at once; write only while busy is low.
// Work per command, each canvas row or line step being a
// read-modify-write of the row memory (a read state, then a write state):
//   point, read: one row access; nop, clear of no rows: none
//   rectangle, triangle: one per row of the height; line: one per step, end included
//   clear: one per active row
//   circle: one per active row (square, 8-step root search, access)
// The circle, with its root search, is the slowest command.
// Reset empties the canvas at once through per-row valid bits and sets
// both active counts to 64.
module bitmap_shape_rasterizer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bsr_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done,
  output bsr_pkg::res_t  result,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [6:0]     cfg_data
);

  bsr_pkg::dp_cmd_t  dp_cmd;
  bsr_pkg::dp_stat_t stat;

  bsr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .dp_cmd (dp_cmd),
    .busy   (busy),
    .done   (done)
  );

  bsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .dp_cmd    (dp_cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

endmodule

@@ rtl/bsr_ctrl.sv @@
`timescale 1ns / 1ps
module bsr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bsr_pkg::dp_stat_t  stat,
  output bsr_pkg::dp_cmd_t   dp_cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SQ,
    S_ROOT,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (start) state <= S_CHECK;
        S_CHECK: begin
          if (stat.empty) state <= S_DONE;
          else if (stat.is_circle) state <= S_SQ;
          else state <= S_RD;
        end
        S_SQ:    state <= S_ROOT;
        S_ROOT:  if (stat.root_done) state <= S_RD;
        S_RD:    state <= S_WR;
        S_WR: begin
          if (stat.last) state <= S_DONE;
          else if (stat.is_circle) state <= S_SQ;
          else state <= S_RD;
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  dp_cmd = start ? bsr_pkg::DP_LOAD : bsr_pkg::DP_NONE;
      S_SQ:    dp_cmd = bsr_pkg::DP_SQ;
      S_ROOT:  dp_cmd = bsr_pkg::DP_ROOT;
      S_RD:    dp_cmd = bsr_pkg::DP_RD;
      S_WR:    dp_cmd = bsr_pkg::DP_WR;
      default: dp_cmd = bsr_pkg::DP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

@@ rtl/bsr_dp.sv @@
`timescale 1ns / 1ps
module bsr_dp (
  input  logic               clk,
  input  logic               rst,
  input  bsr_pkg::cmd_t      cmd,
  input  bsr_pkg::dp_cmd_t   dp_cmd,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output bsr_pkg::dp_stat_t  stat,
  output bsr_pkg::res_t      result
);

  logic [6:0]         rows_in_use;
  logic [6:0]         cols_in_use;
  logic [6:0]         nr;
  logic [6:0]         nc;

  bsr_pkg::mode_t     mode_q;
  logic signed [7:0]  r1, c1, r2, c2;
  logic [7:0]         h, w;
  logic [15:0]        lim;
  logic signed [9:0]  cur_r, cur_c;
  logic [7:0]         cnt;
  logic [7:0]         k;
  logic [2:0]         bitn;
  logic signed [17:0] rem;
  logic [63:0]        rd_bits;
  logic               was_rd;

  logic [63:0]        mem [bsr_pkg::MAX_ROWS];
  logic [63:0]        valid;
  logic [63:0]        mem_q;
  logic               valid_q;

  logic signed [9:0]  r1e, c1e, r2e, c2e;
  logic               in_range;
  logic [bsr_pkg::ROW_AW-1:0] addr;
  logic signed [9:0]  di;
  logic signed [19:0] di_sq;
  logic signed [17:0] rem_next;
  logic [7:0]         trial;
  logic [15:0]        trial_sq;
  logic               fit;
  logic signed [9:0]  lo, hi;
  logic [63:0]        mask;
  logic [63:0]        full;
  logic [63:0]        old;
  logic [63:0]        wdata;
  logic               we;

  assign nr = (rows_in_use > 7'(bsr_pkg::MAX_ROWS)) ? 7'(bsr_pkg::MAX_ROWS) : rows_in_use;
  assign nc = (cols_in_use > 7'(bsr_pkg::MAX_COLS)) ? 7'(bsr_pkg::MAX_COLS) : cols_in_use;

  assign r1e = {{2{r1[7]}}, r1};
  assign c1e = {{2{c1[7]}}, c1};
  assign r2e = {{2{r2[7]}}, r2};
  assign c2e = {{2{c2[7]}}, c2};

  assign in_range = (cur_r >= 10'sd0) && (cur_r < $signed({3'b0, nr}));
  assign addr     = cur_r[bsr_pkg::ROW_AW-1:0];

  assign di       = cur_r - r1e;
  assign di_sq    = di * di;
  assign rem_next = $signed({2'b0, lim}) - $signed({1'b0, di_sq[16:0]});

  assign trial    = k | (8'd1 << bitn);
  assign trial_sq = trial * trial;
  assign fit      = $signed({2'b0, trial_sq}) <= rem;

  always_comb begin
    unique case (mode_q)
      bsr_pkg::MODE_RECT: begin
        lo = c1e;
        hi = c1e + $signed({2'b0, w}) - 10'sd1;
      end
      bsr_pkg::MODE_TRI: begin
        lo = c1e;
        hi = c1e + $signed({2'b0, cnt});
      end
      bsr_pkg::MODE_CIRCLE: begin
        lo = c1e - $signed({2'b0, k});
        hi = c1e + $signed({2'b0, k});
      end
      bsr_pkg::MODE_POINT, bsr_pkg::MODE_LINE: begin
        lo = cur_c;
        hi = cur_c;
      end
      default: begin
        lo = 10'sd0;
        hi = 10'sd63;
      end
    endcase
  end

  assign mask  = bsr_pkg::span_mask(lo, hi, nc);
  assign full  = bsr_pkg::span_mask(10'sd0, 10'sd63, nc);
  assign old   = valid_q ? mem_q : '0;
  assign wdata = (mode_q == bsr_pkg::MODE_CLEAR) ? (old & ~full) : (old | mask);
  // a disc row whose distance already exceeds the radius stays untouched
  assign we    = (dp_cmd == bsr_pkg::DP_WR) && in_range && (mode_q != bsr_pkg::MODE_READ)
                 && !((mode_q == bsr_pkg::MODE_CIRCLE) && (rem < 18'sd0));

  always_comb begin
    stat.is_circle = (mode_q == bsr_pkg::MODE_CIRCLE);
    stat.root_done = (bitn == 3'd0);
    unique case (mode_q)
      bsr_pkg::MODE_RECT:   stat.empty = (w == 8'd0) || (h == 8'd0);
      bsr_pkg::MODE_TRI:    stat.empty = (h == 8'd0);
      bsr_pkg::MODE_CIRCLE,
      bsr_pkg::MODE_CLEAR:  stat.empty = (nr == 7'd0);
      bsr_pkg::MODE_NOP:    stat.empty = 1'b1;
      default:              stat.empty = 1'b0;
    endcase
    unique case (mode_q)
      bsr_pkg::MODE_POINT,
      bsr_pkg::MODE_LINE:   stat.last = (cur_r == r2e) && (cur_c == c2e);
      bsr_pkg::MODE_RECT,
      bsr_pkg::MODE_TRI:    stat.last = (cnt == h - 8'd1);
      bsr_pkg::MODE_CIRCLE,
      bsr_pkg::MODE_CLEAR:  stat.last = (cur_r == $signed({3'b0, nr}) - 10'sd1);
      default:              stat.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'(bsr_pkg::MAX_ROWS);
      cols_in_use <= 7'(bsr_pkg::MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == bsr_pkg::CFG_ROWS) rows_in_use <= cfg_data;
      else cols_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (dp_cmd == bsr_pkg::DP_RD) begin
      mem_q   <= mem[addr];
      valid_q <= valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= bsr_pkg::MODE_NOP;
    end else begin
      unique case (dp_cmd)
        bsr_pkg::DP_LOAD: begin
          mode_q  <= bsr_pkg::mode_t'(cmd.mode);
          r1      <= cmd.start_row;
          c1      <= cmd.start_col;
          // a point is a line that ends where it starts
          r2      <= (cmd.mode == bsr_pkg::MODE_POINT) ? cmd.start_row : cmd.end_row;
          c2      <= (cmd.mode == bsr_pkg::MODE_POINT) ? cmd.start_col : cmd.end_col;
          h       <= cmd.size_h;
          w       <= cmd.size_w;
          lim     <= cmd.size_h * cmd.size_h;
          cur_r   <= (cmd.mode == bsr_pkg::MODE_CIRCLE || cmd.mode == bsr_pkg::MODE_CLEAR)
                     ? 10'sd0 : {{2{cmd.start_row[7]}}, cmd.start_row};
          cur_c   <= {{2{cmd.start_col[7]}}, cmd.start_col};
          cnt     <= '0;
          rd_bits <= '0;
          was_rd  <= 1'b0;
        end
        bsr_pkg::DP_SQ: begin
          rem  <= rem_next;
          k    <= '0;
          bitn <= 3'd7;
        end
        bsr_pkg::DP_ROOT: begin
          if (fit) k <= trial;
          bitn <= bitn - 3'd1;
        end
        bsr_pkg::DP_WR: begin
          if (mode_q == bsr_pkg::MODE_READ) begin
            if (in_range) begin
              rd_bits <= old & full;
              was_rd  <= 1'b1;
            end
          end else if (mode_q == bsr_pkg::MODE_POINT || mode_q == bsr_pkg::MODE_LINE) begin
            if (cur_r != r2e) cur_r <= (r2e > cur_r) ? cur_r + 10'sd1 : cur_r - 10'sd1;
            if (cur_c != c2e) cur_c <= (c2e > cur_c) ? cur_c + 10'sd1 : cur_c - 10'sd1;
          end else begin
            cur_r <= cur_r + 10'sd1;
            cnt   <= cnt + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.row_bits = rd_bits;
  assign result.was_read = was_rd;

endmodule
